// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of aclk outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on the rising edge of aclk outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/embm_pkg.sv =====
// shared constants and types of the embedding best match block
`default_nettype none

package embm_pkg;

    localparam int ELEM_W    = 16;
    localparam int ID_W      = 16;
    localparam int SIM_W     = 16;
    localparam int THR_W     = 15;
    localparam int ACC_W     = 48;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    localparam logic [THR_W-1:0] THR_RESET = 15'd19661;
    localparam logic [SIM_W-1:0] SIM_MAX   = 16'h7FFF;

    // bit positions inside s_tuser
    localparam int TUSER_ABSENT   = 0;
    localparam int TUSER_LAST_REC = 1;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dot_mag;
        logic [ACC_W-1:0] qq;
        logic [ACC_W-1:0] rr;
    } cos_req_t;

    typedef struct packed {
        logic             done;
        logic [SIM_W-1:0] ratio;
    } cos_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/embedding_best_match_top.sv =====
// embedding best match: element accumulation, cosine sequencing and running best
// each element walks mul_dot, acc_dot, acc_qq, acc_rr after acceptance, using the 16x16 multiplier
// a record's last element then waits on the cosine unit, built around a shared
// 24x24 multiplier (8 partial products) and 128-bit adder (sa, sb, and sc for a set bit)
// a record with no embedding or a zero norm skips the cosine unit and goes from check to fin
// the result waits in an output register; the next element is accepted meanwhile
// synchronous active-low reset clears accumulators and running best, threshold to 19661
`default_nettype none
`include "assert_macros.svh"

module embedding_best_match_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [embm_pkg::THR_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // query_elem[15:0], ref_elem[31:16], record_id[47:32]
    input  logic [embm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    // ref_absent[0], last_record[1]
    input  logic [embm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // similarity[15:0], out_record_id[31:16], best_similarity[46:32],
    // best_record_id[62:47], zero[63]
    output logic [embm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // matched
    output logic                           m_tuser
);
    import embm_pkg::*;

    localparam int PROD_W = 2 * ELEM_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_DOT, ST_ACC_DOT, ST_ACC_QQ, ST_ACC_RR, ST_CHECK, ST_WAIT, ST_FIN
    } state_t;

    state_t             state_reg;
    logic [ELEM_W-1:0]  qmag_reg, rmag_reg;
    logic               neg_reg;
    logic [ID_W-1:0]    rid_reg;
    logic               last_elem_reg, last_rec_reg, absent_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   dot_reg, qq_reg, rr_reg;
    logic [SIM_W-1:0]   ratio_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [THR_W-1:0]   best_reg;
    logic [ID_W-1:0]    best_id_reg;
    logic               found_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic               m_last_reg, m_user_reg;

    logic               s_accept;
    logic [ELEM_W-1:0]  in_q, in_r, q_mag_in, r_mag_in;
    logic [ELEM_W-1:0]  mul_a, mul_b;
    logic [2*ELEM_W-1:0] mul_res;
    logic [ACC_W:0]     dot_addend, dot_sum;
    logic [ACC_W-1:0]   dot_next;
    logic [ACC_W-1:0]   norm_add, norm_next;
    logic [ACC_W:0]     norm_sum;
    logic               zero_sim, fin_load;
    logic [SIM_W-1:0]   sim;
    logic               beat, take, found_new;
    logic [THR_W-1:0]   best_new;
    logic [ID_W-1:0]    id_new, best_rid_out;

    cos_req_t           cos_req;
    cos_rsp_t           cos_rsp;

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        s_accept = s_tvalid && s_tready;
        in_q     = s_tdata[ELEM_W-1:0];
        in_r     = s_tdata[2*ELEM_W-1:ELEM_W];
        q_mag_in = in_q[ELEM_W-1] ? (~in_q + 16'd1) : in_q;
        r_mag_in = in_r[ELEM_W-1] ? (~in_r + 16'd1) : in_r;
    end

    // one element multiplier walks q*r, q*q and r*r
    always_comb begin
        case (state_reg)
            ST_MUL_DOT: begin
                mul_a = qmag_reg;
                mul_b = rmag_reg;
            end
            ST_ACC_DOT: begin
                mul_a = qmag_reg;
                mul_b = qmag_reg;
            end
            default: begin
                mul_a = rmag_reg;
                mul_b = rmag_reg;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    // saturating accumulators
    always_comb begin
        dot_addend = neg_reg ? (~{{(ACC_W+1-PROD_W){1'b0}}, prod_reg} + 49'd1)
                             : {{(ACC_W+1-PROD_W){1'b0}}, prod_reg};
        dot_sum    = {dot_reg[ACC_W-1], dot_reg} + dot_addend;
        if (dot_sum[ACC_W] != dot_sum[ACC_W-1])
            dot_next = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            dot_next = dot_sum[ACC_W-1:0];

        norm_add  = (state_reg == ST_ACC_QQ) ? qq_reg : rr_reg;
        norm_sum  = {1'b0, norm_add} + {{(ACC_W+1-PROD_W){1'b0}}, prod_reg};
        norm_next = norm_sum[ACC_W] ? {ACC_W{1'b1}} : norm_sum[ACC_W-1:0];
    end

    always_comb begin
        zero_sim        = absent_reg || (qq_reg == '0) || (rr_reg == '0);
        cos_req.start   = (state_reg == ST_CHECK) && !zero_sim;
        cos_req.dot_mag = dot_reg[ACC_W-1] ? (~dot_reg + 48'd1) : dot_reg;
        cos_req.qq      = qq_reg;
        cos_req.rr      = rr_reg;
    end

    // signed result and running best
    always_comb begin
        if (dot_reg[ACC_W-1])
            sim = ~ratio_reg + 16'd1;
        else
            sim = ratio_reg[SIM_W-1] ? SIM_MAX : ratio_reg;
        beat         = !sim[SIM_W-1] && (sim[THR_W-1:0] > best_reg);
        best_new     = beat ? sim[THR_W-1:0] : best_reg;
        take         = beat && (sim[THR_W-1:0] >= thr_reg);
        found_new    = found_reg || take;
        id_new       = take ? rid_reg : best_id_reg;
        best_rid_out = found_new ? id_new : '0;
        fin_load     = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);
    end

    embm_cosine u_cosine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cos_req),
        .rsp     (cos_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            absent_reg  <= 1'b0;
            dot_reg     <= '0;
            qq_reg      <= '0;
            rr_reg      <= '0;
            best_reg    <= '0;
            best_id_reg <= '0;
            found_reg   <= 1'b0;
            thr_reg     <= THR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            // a load in the same cycle keeps the output register full
            if (m_valid_reg && m_tready && !fin_load)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        qmag_reg      <= q_mag_in;
                        rmag_reg      <= r_mag_in;
                        neg_reg       <= in_q[ELEM_W-1] ^ in_r[ELEM_W-1];
                        rid_reg       <= s_tdata[2*ELEM_W+ID_W-1:2*ELEM_W];
                        last_elem_reg <= s_tlast;
                        last_rec_reg  <= s_tuser[TUSER_LAST_REC];
                        absent_reg    <= absent_reg | s_tuser[TUSER_ABSENT];
                        state_reg     <= ST_MUL_DOT;
                    end
                end
                ST_MUL_DOT: begin
                    prod_reg  <= mul_res[PROD_W-1:0];
                    state_reg <= ST_ACC_DOT;
                end
                ST_ACC_DOT: begin
                    dot_reg   <= dot_next;
                    prod_reg  <= mul_res[PROD_W-1:0];
                    state_reg <= ST_ACC_QQ;
                end
                ST_ACC_QQ: begin
                    qq_reg    <= norm_next;
                    prod_reg  <= mul_res[PROD_W-1:0];
                    state_reg <= ST_ACC_RR;
                end
                ST_ACC_RR: begin
                    rr_reg    <= norm_next;
                    state_reg <= last_elem_reg ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK: begin
                    if (zero_sim) begin
                        ratio_reg <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (cos_rsp.done) begin
                        ratio_reg <= cos_rsp.ratio;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_load) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, best_rid_out, best_new, rid_reg, sim};
                        m_last_reg  <= last_rec_reg;
                        m_user_reg  <= found_new;
                        dot_reg     <= '0;
                        qq_reg      <= '0;
                        rr_reg      <= '0;
                        absent_reg  <= 1'b0;
                        if (last_rec_reg) begin
                            best_reg    <= '0;
                            best_id_reg <= '0;
                            found_reg   <= 1'b0;
                        end else begin
                            best_reg    <= best_new;
                            best_id_reg <= id_new;
                            found_reg   <= found_new;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_IMPL(a_done_while_waiting, cos_rsp.done, state_reg == ST_WAIT)
    `ASSERT_NEXT(a_record_cleared, fin_load, dot_reg == '0 && qq_reg == '0 && rr_reg == '0)
    `ASSERT_IMPL(a_id_needs_match, !found_reg, best_id_reg == '0)

endmodule

`default_nettype wire

// ===== hdl/embm_cosine.sv =====
// iterative cosine ratio unit: shared 24x24 multiplier and one 128-bit adder
`default_nettype none
`include "assert_macros.svh"

module embm_cosine (
    input  logic               aclk,
    input  logic               aresetn,
    input  embm_pkg::cos_req_t req,
    output embm_pkg::cos_rsp_t rsp
);
    import embm_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int WIDE_W = 128;
    localparam int PROD_W = 2 * ACC_W;
    localparam int T_W    = PROD_W + SIM_W;
    localparam int PP_LAST = 8;

    typedef enum logic [2:0] {C_IDLE, C_PP, C_SA, C_SB, C_SC} cstate_t;

    cstate_t            state_reg;
    logic [3:0]         pp_cnt_reg;
    logic [1:0]         sh_reg;
    logic [3:0]         bit_reg;
    logic [ACC_W-1:0]   d_reg, q_reg, r_reg;
    logic [ACC_W-1:0]   prod_reg;
    logic [WIDE_W-1:0]  w_acc_reg, n_reg, s_reg, x_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [T_W-1:0]     t_reg;
    logic [SIM_W-1:0]   k_reg;
    logic               done_reg;

    logic [2:0]         pp_idx;
    logic [ACC_W-1:0]   op_a, op_b;
    logic [HALF_W-1:0]  half_a, half_b;
    logic [ACC_W-1:0]   mul_res;
    logic [WIDE_W-1:0]  add_a, add_b, sum;
    logic               fits;

    assign pp_idx = pp_cnt_reg[2:0];

    // partial products: d*d for the first four, qq*rr for the next four
    always_comb begin
        op_a    = pp_idx[2] ? q_reg : d_reg;
        op_b    = pp_idx[2] ? r_reg : d_reg;
        half_a  = pp_idx[1] ? op_a[ACC_W-1:HALF_W] : op_a[HALF_W-1:0];
        half_b  = pp_idx[0] ? op_b[ACC_W-1:HALF_W] : op_b[HALF_W-1:0];
        mul_res = half_a * half_b;
    end

    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            C_PP: begin
                add_a = w_acc_reg;
                case (sh_reg)
                    2'd0:    add_b = {{(WIDE_W-ACC_W){1'b0}}, prod_reg};
                    2'd1:    add_b = {{(WIDE_W-ACC_W-HALF_W){1'b0}}, prod_reg,
                                      {HALF_W{1'b0}}};
                    2'd2:    add_b = {{(WIDE_W-2*ACC_W){1'b0}}, prod_reg, {ACC_W{1'b0}}};
                    default: add_b = '0;
                endcase
            end
            C_SA: begin
                add_a = s_reg;
                add_b = {{(WIDE_W-PROD_W){1'b0}}, p_reg} << {bit_reg, 1'b0};
            end
            C_SB: begin
                add_a = x_reg;
                add_b = {{(WIDE_W-T_W){1'b0}}, t_reg} << ({1'b0, bit_reg} + 5'd1);
            end
            C_SC: begin
                add_a = {{(WIDE_W-T_W){1'b0}}, t_reg};
                add_b = {{(WIDE_W-PROD_W){1'b0}}, p_reg} << bit_reg;
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
        sum  = add_a + add_b;
        // trial (k | bit)^2 * qq * rr against dot^2 << 30, ratio capped at one
        fits = (sum <= n_reg) && !k_reg[SIM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= C_IDLE;
            pp_cnt_reg <= '0;
            bit_reg    <= '0;
            k_reg      <= '0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (req.start) begin
                        d_reg      <= req.dot_mag;
                        q_reg      <= req.qq;
                        r_reg      <= req.rr;
                        w_acc_reg  <= '0;
                        pp_cnt_reg <= '0;
                        state_reg  <= C_PP;
                    end
                end
                C_PP: begin
                    if (pp_cnt_reg < 4'(PP_LAST)) begin
                        prod_reg <= mul_res;
                        sh_reg   <= {1'b0, pp_idx[1]} + {1'b0, pp_idx[0]};
                    end
                    if (pp_cnt_reg == 4'(PP_LAST / 2)) begin
                        n_reg     <= {sum[WIDE_W-31:0], 30'd0};
                        w_acc_reg <= '0;
                    end else if (pp_cnt_reg == 4'(PP_LAST)) begin
                        p_reg     <= sum[PROD_W-1:0];
                        s_reg     <= '0;
                        t_reg     <= '0;
                        k_reg     <= '0;
                        bit_reg   <= 4'(SIM_W - 1);
                        state_reg <= C_SA;
                    end else if (pp_cnt_reg != 4'd0) begin
                        w_acc_reg <= sum;
                    end
                    pp_cnt_reg <= pp_cnt_reg + 4'd1;
                end
                C_SA: begin
                    x_reg     <= sum;
                    state_reg <= C_SB;
                end
                C_SB: begin
                    if (fits) begin
                        s_reg          <= sum;
                        k_reg[bit_reg] <= 1'b1;
                        state_reg      <= C_SC;
                    end else if (bit_reg == 4'd0) begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end else begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= C_SA;
                    end
                end
                C_SC: begin
                    t_reg <= sum[T_W-1:0];
                    if (bit_reg == 4'd0) begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end else begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= C_SA;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.ratio = k_reg;

    `ASSERT_IMPL(a_start_when_idle, req.start, state_reg == C_IDLE)
    `ASSERT_IMPL(a_ratio_capped, 1'b1, k_reg <= 16'h8000)
    `ASSERT_NEXT(a_done_single, done_reg, !done_reg && state_reg == C_IDLE)

endmodule

`default_nettype wire

// ===== test/embedding_best_match_top_test.sv =====
// self-checking stream test of the embedding best match block with its own cosine predictor
`timescale 1ns / 100ps

module embedding_best_match_top_test;
    import embm_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 680;
    localparam int MAX_REPORTS   = 10;
    localparam int OVERLONG_LEN  = 520;

    localparam longint DOT_MAX = 64'sd140737488355327;
    localparam longint DOT_MIN = -64'sd140737488355328;
    localparam longint unsigned NORM_MAX = 64'hFFFF_FFFF_FFFF;

    typedef enum logic {ROW_ITEM, ROW_THRESHOLD} row_kind_t;

    typedef struct {
        logic signed [ELEM_W-1:0] q;
        logic signed [ELEM_W-1:0] r;
        logic [ID_W-1:0]          id;
        bit                       absent;
        bit                       last_elem;
        bit                       last_rec;
    } elem_pair_t;

    typedef struct packed {
        logic [SIM_W-1:0] sim;
        logic [ID_W-1:0]  rid;
        logic [THR_W-1:0] best;
        logic [ID_W-1:0]  best_id;
        logic             matched;
        logic             done;
        logic             pad;
    } score_rec_t;

    typedef struct {
        row_kind_t        kind;
        elem_pair_t       item;
        int               count;
        bit               known;
        score_rec_t       want;
        logic [THR_W-1:0] thr;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [THR_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    // predictor state
    logic signed [ACC_W-1:0] acc_dot;
    logic [ACC_W-1:0]        acc_qq;
    logic [ACC_W-1:0]        acc_rr;
    bit                      absent_flag;
    int                      best_val;
    logic [ID_W-1:0]         best_rid;
    bit                      match_flag;
    logic [THR_W-1:0]        threshold_reg;

    score_rec_t expected_scores[$];
    stim_row_t  directed_rows[$];
    int         error_count;
    int         report_count;
    int         cycle_count;
    bit         hold_off_req;
    bit         steady_flow;

    embedding_best_match_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 100);
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // floor(32768 * |dot| / sqrt(qq * rr)) found bit by bit on squared terms
    function automatic logic [SIM_W-1:0] cosine_from_sums();
        logic [ACC_W-1:0] mag;
        logic [127:0]     prod, num, trial;
        logic [16:0]      k, c;
        if (absent_flag || acc_qq == 0 || acc_rr == 0)
            return '0;
        mag = acc_dot[ACC_W-1] ? -acc_dot : acc_dot;
        prod = {80'd0, acc_qq} * {80'd0, acc_rr};
        num = ({80'd0, mag} * {80'd0, mag}) << 30;
        k = '0;
        for (int b = 15; b >= 0; b--) begin
            c = k | (17'd1 << b);
            trial = prod * ({111'd0, c} * {111'd0, c});
            if (c <= 17'd32768 && trial <= num)
                k = c;
        end
        if (acc_dot[ACC_W-1])
            return -k[SIM_W-1:0];
        if (k > 17'd32767)
            return SIM_MAX;
        return k[SIM_W-1:0];
    endfunction

    // fold one element pair into the sums; on a record end work out its result
    function automatic bit score_element(input elem_pair_t it, output score_rec_t res);
        longint                  qv, rv, d;
        longint unsigned         nq, nr;
        logic signed [SIM_W-1:0] sim;
        int                      sim_i, thr_i;
        qv = it.q;
        rv = it.r;
        res = '0;
        if (it.absent)
            absent_flag = 1'b1;
        d = acc_dot + qv * rv;
        if (d > DOT_MAX)
            d = DOT_MAX;
        if (d < DOT_MIN)
            d = DOT_MIN;
        acc_dot = d[ACC_W-1:0];
        nq = acc_qq + qv * qv;
        nr = acc_rr + rv * rv;
        acc_qq = (nq > NORM_MAX) ? NORM_MAX[ACC_W-1:0] : nq[ACC_W-1:0];
        acc_rr = (nr > NORM_MAX) ? NORM_MAX[ACC_W-1:0] : nr[ACC_W-1:0];
        if (!it.last_elem)
            return 1'b0;

        sim = cosine_from_sums();
        sim_i = sim;
        thr_i = threshold_reg;
        if (sim_i > best_val) begin
            best_val = sim_i;
            if (sim_i >= thr_i) begin
                match_flag = 1'b1;
                best_rid = it.id;
            end
        end
        res.sim = sim;
        res.rid = it.id;
        res.best = best_val[THR_W-1:0];
        res.best_id = match_flag ? best_rid : '0;
        res.matched = match_flag;
        res.done = it.last_rec;

        acc_dot = '0;
        acc_qq = '0;
        acc_rr = '0;
        absent_flag = 1'b0;
        if (it.last_rec) begin
            best_val = 0;
            best_rid = '0;
            match_flag = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void add_items(int q, int r, int id, bit absent, bit last_elem,
                                      bit last_rec, int count);
        stim_row_t row;
        row = '{kind: ROW_ITEM, default: '0};
        row.kind = ROW_ITEM;
        row.item = '{ELEM_W'(q), ELEM_W'(r), ID_W'(id), absent, last_elem, last_rec};
        row.count = count;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // single record-closing element whose result is plain to see
    function automatic void add_known(int q, int r, int id, bit last_rec, int sim, int rid,
                                      int best, int best_id, bit matched, bit done);
        stim_row_t row;
        row = '{kind: ROW_ITEM, default: '0};
        row.kind = ROW_ITEM;
        row.item = '{ELEM_W'(q), ELEM_W'(r), ID_W'(id), 1'b0, 1'b1, last_rec};
        row.count = 1;
        row.known = 1'b1;
        row.want = '{SIM_W'(sim), ID_W'(rid), THR_W'(best), ID_W'(best_id), matched, done,
                     1'b0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_threshold(int thr);
        stim_row_t row;
        row = '{kind: ROW_THRESHOLD, default: '0};
        row.kind = ROW_THRESHOLD;
        row.thr = THR_W'(thr);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input elem_pair_t it, input bit back_to_back, input bit known,
                             input score_rec_t want);
        int                   gap;
        logic [S_TUSER_W-1:0] user;
        score_rec_t           predicted;
        gap = (back_to_back || steady_flow) ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        user = '0;
        user[TUSER_ABSENT] = it.absent;
        user[TUSER_LAST_REC] = it.last_rec;
        s_tvalid <= 1'b1;
        s_tdata <= {it.id, it.r, it.q};
        s_tlast <= it.last_elem;
        s_tuser <= user;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (score_element(it, predicted))
            expected_scores.insert(expected_scores.size(), known ? want : predicted);
        @(negedge aclk);
    endtask

    // only with nothing in flight: drain, let the back end settle, then write
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        threshold_reg = thr;
    endtask

    task automatic run_random_sets();
        int         items_sent, n_rec, len, style, noise, scale, pick;
        elem_pair_t it;
        score_rec_t none;
        none = '0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: write_threshold('0);
                    1: write_threshold(15'h7FFF);
                    2: write_threshold(THR_RESET);
                    3: write_threshold(THR_W'($urandom_range(28000, 32767)));
                    default: write_threshold(THR_W'($urandom_range(0, 32767)));
                endcase
            end
            steady_flow = ($urandom_range(0, 5) == 0);
            n_rec = $urandom_range(1, 6);
            for (int rec = 0; rec < n_rec; rec++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                style = $urandom_range(0, 5);
                scale = $urandom_range(1, 4);
                noise = ($urandom_range(0, 1) == 0) ? 50 : 2000;
                it.id = ID_W'($urandom);
                for (int e = 0; e < len; e++) begin
                    it.q = ELEM_W'($urandom);
                    it.r = ELEM_W'($urandom);
                    case (style)
                        1: it.r = ELEM_W'(clamp16(int'(it.q) * scale / 4
                                          + int'($urandom_range(0, 2 * noise)) - noise));
                        2: it.r = ELEM_W'(clamp16(-int'(it.q)
                                          + int'($urandom_range(0, 2 * noise)) - noise));
                        3: begin
                            it.q = ELEM_W'(int'($urandom_range(0, 16)) - 8);
                            it.r = ELEM_W'(int'($urandom_range(0, 16)) - 8);
                        end
                        4: begin
                            pick = $urandom_range(0, 4);
                            it.q = ELEM_W'((pick == 0) ? -32768 : (pick == 1) ? 32767 : pick - 3);
                            pick = $urandom_range(0, 4);
                            it.r = ELEM_W'((pick == 0) ? -32768 : (pick == 1) ? 32767 : pick - 3);
                        end
                        5: it.q = '0;
                        default: ;
                    endcase
                    it.absent = ($urandom_range(0, 19) == 0);
                    it.last_elem = (e == len - 1);
                    // stray set-end flags mid record are noise the block must ignore
                    it.last_rec = it.last_elem ? (rec == n_rec - 1) : ($urandom_range(0, 15) == 0);
                    send_item(it, 1'b0, 1'b0, none);
                    items_sent++;
                    if (items_sent == RANDOM_ITEMS / 2)
                        hold_off_req = 1'b1;
                end
            end
        end
    endtask

    // receiver side
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (steady_flow) begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_gap() + 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        score_rec_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.sim = m_tdata[15:0];
            got.rid = m_tdata[31:16];
            got.best = m_tdata[46:32];
            got.best_id = m_tdata[62:47];
            got.pad = m_tdata[63];
            got.matched = m_tuser;
            got.done = m_tlast;
            if (expected_scores.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected result transfer: sim %h id %h", got.sim, got.rid);
                report_count++;
            end else begin
                want = expected_scores.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        $display("mismatch: exp sim %h id %h best %h best_id %h m %b d %b p %b",
                                 want.sim, want.rid, want.best, want.best_id, want.matched,
                                 want.done, want.pad);
                        $display("          got sim %h id %h best %h best_id %h m %b d %b p %b",
                                 got.sim, got.rid, got.best, got.best_id, got.matched,
                                 got.done, got.pad);
                    end
                    report_count++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = '0;
        cycle_count = 0;
        error_count = 0;
        report_count = 0;
        hold_off_req = 1'b0;
        steady_flow = 1'b0;
        acc_dot = '0;
        acc_qq = '0;
        acc_rr = '0;
        absent_flag = 1'b0;
        best_val = 0;
        best_rid = '0;
        match_flag = 1'b0;
        threshold_reg = THR_RESET;

        // identical and opposite full-scale vectors, tie at the top, set close
        add_known(32767, 32767, 16'h1234, 0, 32767, 16'h1234, 32767, 16'h1234, 1, 0);
        add_known(32767, -32767, 16'h0001, 0, 16'h8000, 16'h0001, 32767, 16'h1234, 1, 0);
        add_known(-32768, -32768, 16'hFFFF, 1, 32767, 16'hFFFF, 32767, 16'h1234, 1, 1);
        // negative similarity against a fresh best of zero
        add_known(-5, 5, 16'h0002, 0, 16'h8000, 16'h0002, 0, 0, 0, 0);
        // absent embedding flagged on an earlier element of the record
        add_items(100, 100, 16'h0005, 1, 0, 0, 1);
        add_known(200, 300, 16'h0005, 0, 0, 16'h0005, 0, 0, 0, 0);
        // zero query norm
        add_known(0, 1234, 16'h0006, 0, 0, 16'h0006, 0, 0, 0, 0);
        // set end flagged without a record end is ignored
        add_items(1000, 2000, 16'h0007, 0, 0, 1, 1);
        add_items(-1000, 500, 16'h0007, 0, 1, 0, 1);
        add_items(3, 4, 16'h0008, 0, 0, 0, 1);
        add_items(4, 3, 16'h0008, 0, 1, 1, 1);
        add_threshold(15'h7FFF);
        add_known(12000, 9000, 16'h0009, 0, 32767, 16'h0009, 32767, 16'h0009, 1, 0);
        add_items(3, 4, 16'h000A, 0, 0, 0, 1);
        add_items(4, 3, 16'h000A, 0, 1, 1, 1);
        add_threshold(0);
        add_items(1, 1, 16'h000B, 0, 0, 0, 1);
        add_items(0, 1, 16'h000B, 0, 1, 1, 1);
        // vector longer than its nominal length, full-scale elements throughout
        add_items(-32768, -32768, 16'hBEEF, 0, 0, 0, OVERLONG_LEN);
        add_known(-32768, -32768, 16'hBEEF, 1, 32767, 16'hBEEF, 32767, 16'hBEEF, 1, 1);
        add_threshold(THR_RESET);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_THRESHOLD) begin
                write_threshold(directed_rows[i].thr);
            end else begin
                for (int n = 0; n < directed_rows[i].count; n++)
                    send_item(directed_rows[i].item, directed_rows[i].count > 1,
                              directed_rows[i].known, directed_rows[i].want);
            end
        end

        run_random_sets();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_scores.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
